[sv/cvh_pkg.sv]
// shared types, constants and status codes for the gift-wrap convex hull block
package cvh_pkg;

   localparam int COORD_BITS      = 16;
   localparam int MAX_POINTS_DEF  = 32;
   localparam int MIN_HULL_POINTS = 3;
   localparam int POINT_BITS      = 2 * COORD_BITS;
   localparam int DIFF_BITS       = COORD_BITS + 1;
   localparam int PROD_BITS       = 2 * DIFF_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   // x in the low half, y in the high half
   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   typedef logic [1:0] status_type;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FEW   = 2'd1;
   localparam status_type STAT_GUARD = 2'd2;

endpackage

[sv/cvh_ram.sv]
// generic single write port ram with one registered read port
module cvh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/convex_hull_gift_wrap_top.sv]
// top level of the gift-wrap (jarvis march) convex hull block
// points load one per cycle; after the last point S_FIRST registers the first result when
//   the output is free; each vertex: S_CAND, S_CWAIT, S_MUL1/S_MUL2 per point, S_EMIT
// throughput: one run at a time; the hull scan is bound by the one shared multiplier
//   (two cross-product terms per scanned point) and the single read port of the point ram
// reset: synchronous active high, returns to loading with an empty store and no result pending
module convex_hull_gift_wrap_top #(
   parameter int MAX_POINTS = cvh_pkg::MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // point input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   input  logic        req_tlast,   // last_point
   // hull vertex output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] hull_x, [31:16] hull_y
   output logic        rsp_tlast,   // end_of_hull
   output logic [1:0]  rsp_tuser    // [1:0] hull_status
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // sequencer codes
   localparam logic [2:0] S_LOAD  = 3'd0;  // taking points
   localparam logic [2:0] S_FIRST = 3'd1;  // emit leftmost point or too-few status
   localparam logic [2:0] S_CAND  = 3'd2;  // read the starting candidate
   localparam logic [2:0] S_CWAIT = 3'd3;  // capture candidate, start scan at index 0
   localparam logic [2:0] S_MUL1  = 3'd4;  // first cross-product term
   localparam logic [2:0] S_MUL2  = 3'd5;  // second term, compare, maybe replace candidate
   localparam logic [2:0] S_EMIT  = 3'd6;  // advance to the chosen vertex and emit it

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;      // stored points, saturates
   logic [CNT_W-1:0]          emitted_ff, emitted_in;  // results of the current run
   logic [IDX_W-1:0]          lm_idx_ff, lm_idx_in;
   cvh_pkg::point_type        lm_pt_ff, lm_pt_in;
   logic [IDX_W-1:0]          cur_idx_ff, cur_idx_in;
   cvh_pkg::point_type        cur_pt_ff, cur_pt_in;
   logic [IDX_W-1:0]          cand_idx_ff, cand_idx_in;
   cvh_pkg::point_type        cand_pt_ff, cand_pt_in;
   logic [IDX_W-1:0]          scan_ff, scan_in;
   cvh_pkg::point_type        q_pt_ff, q_pt_in;        // scanned point held for second term
   cvh_pkg::prod_type         prod_ff, prod_in;        // first cross-product term

   // output register
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   cvh_pkg::point_type        rsp_pt_ff, rsp_pt_in;
   logic                      rsp_last_ff, rsp_last_in;
   cvh_pkg::status_type       rsp_status_ff, rsp_status_in;

   // point store
   logic                      wr_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [cvh_pkg::POINT_BITS-1:0] rd_data;
   cvh_pkg::point_type        rd_pt;
   cvh_pkg::point_type        in_pt;

   // shared multiplier
   cvh_pkg::diff_type         mul_a;
   cvh_pkg::diff_type         mul_b;
   cvh_pkg::prod_type         mul_p;

   logic                      out_free;
   logic                      req_beat;
   logic                      store_room;
   logic                      lm_better;
   logic [CNT_W-1:0]          cur_next;
   logic [IDX_W-1:0]          cand_start;
   logic                      scan_done;
   logic                      turn_right;
   logic                      same_pt;

   assign in_pt      = cvh_pkg::point_type'(req_tdata);
   assign rd_pt      = cvh_pkg::point_type'(rd_data);
   assign req_tready = (state_ff == S_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign store_room = (count_ff < CNT_W'(MAX_POINTS));
   assign wr_en      = req_beat && store_room;

   // leftmost point tracked while loading: smaller x, ties at smaller y, first one wins
   assign lm_better = (count_ff == '0) || (in_pt.x < lm_pt_ff.x) ||
                      ((in_pt.x == lm_pt_ff.x) && (in_pt.y < lm_pt_ff.y));

   // starting candidate is the index after the current vertex, wrapping at n
   assign cur_next   = CNT_W'(cur_idx_ff) + CNT_W'(1);
   assign cand_start = (cur_next == count_ff) ? '0 : cur_next[IDX_W-1:0];
   assign scan_done  = (CNT_W'(scan_ff) + CNT_W'(1) == count_ff);

   // operand select for the one multiplier:
   // first term (cand.x - cur.x) * (q.y - cur.y), second (cand.y - cur.y) * (q.x - cur.x)
   always_comb begin
      if (state_ff == S_MUL1) begin
         mul_a = cvh_pkg::diff_type'(cand_pt_ff.x) - cvh_pkg::diff_type'(cur_pt_ff.x);
         mul_b = cvh_pkg::diff_type'(rd_pt.y) - cvh_pkg::diff_type'(cur_pt_ff.y);
      end else begin
         mul_a = cvh_pkg::diff_type'(cand_pt_ff.y) - cvh_pkg::diff_type'(cur_pt_ff.y);
         mul_b = cvh_pkg::diff_type'(q_pt_ff.x) - cvh_pkg::diff_type'(cur_pt_ff.x);
      end
   end

   assign mul_p      = mul_a * mul_b;
   // cross product below zero: scanned point strictly right of current->candidate
   assign turn_right = (prod_ff < mul_p);
   assign same_pt    = (q_pt_ff == cand_pt_ff);

   // read address: candidate fetch, scan start, then one ahead during the second term
   always_comb begin
      case (state_ff)
         S_CAND:  rd_addr = cand_start;
         S_CWAIT: rd_addr = '0;
         S_MUL2:  rd_addr = scan_ff + IDX_W'(1);
         default: rd_addr = scan_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      emitted_in    = emitted_ff;
      lm_idx_in     = lm_idx_ff;
      lm_pt_in      = lm_pt_ff;
      cur_idx_in    = cur_idx_ff;
      cur_pt_in     = cur_pt_ff;
      cand_idx_in   = cand_idx_ff;
      cand_pt_in    = cand_pt_ff;
      scan_in       = scan_ff;
      q_pt_in       = q_pt_ff;
      prod_in       = prod_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_pt_in     = rsp_pt_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_beat) begin
               if (store_room) begin
                  count_in = count_ff + CNT_W'(1);
                  if (lm_better) begin
                     lm_idx_in = count_ff[IDX_W-1:0];
                     lm_pt_in  = in_pt;
                  end
               end
               if (req_tlast) begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (count_ff < CNT_W'(cvh_pkg::MIN_HULL_POINTS)) begin
                  // too few points for a hull
                  rsp_pt_in     = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = cvh_pkg::STAT_FEW;
                  count_in      = '0;
                  state_in      = S_LOAD;
               end else begin
                  rsp_pt_in     = lm_pt_ff;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = cvh_pkg::STAT_OK;
                  cur_idx_in    = lm_idx_ff;
                  cur_pt_in     = lm_pt_ff;
                  emitted_in    = CNT_W'(1);
                  state_in      = S_CAND;
               end
            end
         end
         S_CAND: begin
            cand_idx_in = cand_start;
            state_in    = S_CWAIT;
         end
         S_CWAIT: begin
            cand_pt_in = rd_pt;
            scan_in    = '0;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            prod_in  = mul_p;
            q_pt_in  = rd_pt;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (!same_pt && turn_right) begin
               cand_idx_in = scan_ff;
               cand_pt_in  = q_pt_ff;
            end
            scan_in  = scan_ff + IDX_W'(1);
            state_in = scan_done ? S_EMIT : S_MUL1;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_pt_in     = cand_pt_ff;
               cur_idx_in    = cand_idx_ff;
               cur_pt_in     = cand_pt_ff;
               if (cand_idx_ff == lm_idx_ff) begin
                  // wrapped back to the leftmost point
                  rsp_last_in   = 1'b1;
                  rsp_status_in = cvh_pkg::STAT_OK;
                  count_in      = '0;
                  emitted_in    = '0;
                  state_in      = S_LOAD;
               end else if (emitted_ff == CNT_W'(MAX_POINTS)) begin
                  // step guard: this is result MAX_POINTS+1
                  rsp_last_in   = 1'b1;
                  rsp_status_in = cvh_pkg::STAT_GUARD;
                  count_in      = '0;
                  emitted_in    = '0;
                  state_in      = S_LOAD;
               end else begin
                  rsp_last_in   = 1'b0;
                  rsp_status_in = cvh_pkg::STAT_OK;
                  emitted_in    = emitted_ff + CNT_W'(1);
                  state_in      = S_CAND;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         emitted_ff    <= '0;
         lm_idx_ff     <= '0;
         cur_idx_ff    <= '0;
         cand_idx_ff   <= '0;
         scan_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         emitted_ff    <= emitted_in;
         lm_idx_ff     <= lm_idx_in;
         cur_idx_ff    <= cur_idx_in;
         cand_idx_ff   <= cand_idx_in;
         scan_ff       <= scan_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lm_pt_ff      <= lm_pt_in;
      cur_pt_ff     <= cur_pt_in;
      cand_pt_ff    <= cand_pt_in;
      q_pt_ff       <= q_pt_in;
      prod_ff       <= prod_in;
      rsp_pt_ff     <= rsp_pt_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   cvh_ram #(
      .WIDTH (cvh_pkg::POINT_BITS),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pt_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // result count of a run never passes the step guard
   a_emitted_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= CNT_W'(MAX_POINTS))
      else $error("emitted count beyond step guard");

   // scan and candidate stay inside the stored set while wrapping
   a_scan_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL1 || state_ff == S_MUL2) |->
         (CNT_W'(scan_ff) < count_ff) && (CNT_W'(cand_idx_ff) < count_ff))
      else $error("scan or candidate index outside stored points");

   // a guard or too-few status only ever closes a run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != cvh_pkg::STAT_OK) |-> rsp_tlast)
      else $error("error status on a beat that does not end the run");

   // a result is only created while the output register is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("pending result overwritten");

endmodule

[bench/testbench.sv]
// self-checking bench for the gift-wrap convex hull block with a built-in hull predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = cvh_pkg::MAX_POINTS_DEF;
   localparam int GUARD_STEPS  = STORE_DEPTH + 1;
   localparam int ITEM_TARGET  = 310;
   // worst correct run is far below this: ~40 sets of up to 33 vertices each
   localparam int CYCLE_LIMIT  = 1_000_000;
   // drain time sized to cover two vertex steps for a full store
   localparam int DRAIN_CYCLES = 4 * STORE_DEPTH + 20;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      cvh_pkg::coord_type  x;
      cvh_pkg::coord_type  y;
      logic                last;
      cvh_pkg::status_type status;
   } vertex_type;

   // point store, hull predictor and the queue of vertices still to come
   class hull_scoreboard;
      cvh_pkg::coord_type store_x [STORE_DEPTH];
      cvh_pkg::coord_type store_y [STORE_DEPTH];
      int          loaded;
      vertex_type  hull_expected [$];
      int          failures;
      int          runs;
      int          points;
      int          vertices;
      int          short_sets;
      int          guard_stops;

      function void push_vertex(cvh_pkg::coord_type x, cvh_pkg::coord_type y, logic last,
                                cvh_pkg::status_type status);
         vertex_type v;
         v.x      = x;
         v.y      = y;
         v.last   = last;
         v.status = status;
         hull_expected = {hull_expected, v};
      endfunction

      // point r strictly right of the directed line a -> b
      function bit right_of(int a, int b, int r);
         longint ax, ay, bx, by, rx, ry, cr;
         ax = store_x[a];
         ay = store_y[a];
         bx = store_x[b];
         by = store_y[b];
         rx = store_x[r];
         ry = store_y[r];
         cr = (bx - ax) * (ry - ay) - (by - ay) * (rx - ax);
         return cr < 0;
      endfunction

      function void wrap_hull();
         int n;
         int left;
         int cur;
         int cand;
         int steps;
         n = loaded;
         runs++;
         if (n < cvh_pkg::MIN_HULL_POINTS) begin
            short_sets++;
            push_vertex('0, '0, 1'b1, cvh_pkg::STAT_FEW);
            return;
         end
         left = 0;
         for (int i = 1; i < n; i++) begin
            if (store_x[i] < store_x[left] ||
                (store_x[i] == store_x[left] && store_y[i] < store_y[left]))
               left = i;
         end
         cur = left;
         push_vertex(store_x[cur], store_y[cur], 1'b0, cvh_pkg::STAT_OK);
         steps = 1;
         forever begin
            cand = (cur + 1) % n;
            for (int s = 0; s < n; s++) begin
               if (!(store_x[s] == store_x[cand] && store_y[s] == store_y[cand]) &&
                   right_of(cur, cand, s))
                  cand = s;
            end
            cur = cand;
            steps++;
            if (cur == left) begin
               push_vertex(store_x[cur], store_y[cur], 1'b1, cvh_pkg::STAT_OK);
               break;
            end
            if (steps >= GUARD_STEPS) begin
               guard_stops++;
               push_vertex(store_x[cur], store_y[cur], 1'b1, cvh_pkg::STAT_GUARD);
               break;
            end
            push_vertex(store_x[cur], store_y[cur], 1'b0, cvh_pkg::STAT_OK);
         end
      endfunction

      function void note_point(cvh_pkg::coord_type x, cvh_pkg::coord_type y, logic last);
         points++;
         // points past a full store are dropped
         if (loaded < STORE_DEPTH) begin
            store_x[loaded] = x;
            store_y[loaded] = y;
            loaded++;
         end
         if (last) begin
            wrap_hull();
            loaded = 0;
         end
      endfunction

      function void check_vertex(cvh_pkg::coord_type x, cvh_pkg::coord_type y, logic last,
                                 cvh_pkg::status_type status);
         vertex_type want;
         if (hull_expected.size() == 0) begin
            $display("%0t: unexpected vertex x=%0d y=%0d last=%0b status=%0d",
                     $time, x, y, last, status);
            failures++;
            return;
         end
         want = hull_expected.pop_front();
         vertices++;
         if (x !== want.x) begin
            $display("%0t: hull_x expected %0d actual %0d", $time, want.x, x);
            failures++;
         end
         if (y !== want.y) begin
            $display("%0t: hull_y expected %0d actual %0d", $time, want.y, y);
            failures++;
         end
         if (last !== want.last) begin
            $display("%0t: end_of_hull expected %0b actual %0b", $time, want.last, last);
            failures++;
         end
         if (status !== want.status) begin
            $display("%0t: hull_status expected %0d actual %0d", $time, want.status, status);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [15:0] point_x, [31:16] point_y
   logic        req_tlast;    // last_point
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [15:0] hull_x, [31:16] hull_y
   logic        rsp_tlast;    // end_of_hull
   logic [1:0]  rsp_tuser;    // [1:0] hull_status

   hull_scoreboard     hull_sb = new();
   int                 items_sent = 0;
   int                 cycle_count = 0;
   cvh_pkg::coord_type set_x [$];
   cvh_pkg::coord_type set_y [$];

   convex_hull_gift_wrap_top #(
      .MAX_POINTS(STORE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, counts every cycle of the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog: no progress after %0d cycles, %0d vertices outstanding",
                  cycle_count, hull_sb.hull_expected.size());
         $display("tb: failure");
         $finish;
      end
   end

   // every accepted result beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         hull_sb.check_vertex(cvh_pkg::coord_type'(rsp_tdata[15:0]),
                              cvh_pkg::coord_type'(rsp_tdata[31:16]),
                              rsp_tlast, rsp_tuser);
   end

   // result sink: random back-pressure, one long hold-off once the first
   // hulls are out, then a stretch of always-ready
   initial begin : result_sink
      int hold_left;
      bit held;
      hold_left  = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && hull_sb.vertices >= 10) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            // sender keeps offering points meanwhile, so the block backs up
            hold_left--;
            rsp_tready = 1'b0;
         end else if (reset) begin
            rsp_tready = 1'b0;
         end else if (hull_sb.vertices >= 40 && hull_sb.vertices < 90) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(99) >= 25);
         end
      end
   end

   // one point beat; idles at random except inside a steady window of items
   task automatic send_point(cvh_pkg::coord_type x, cvh_pkg::coord_type y, logic last);
      bit steady;
      steady = (items_sent >= 150 && items_sent < 230);
      while (!steady && $urandom_range(99) < 25) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {y, x};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      hull_sb.note_point(x, y, last);
      items_sent++;
   endtask

   task automatic add_point(int x, int y);
      set_x = {set_x, cvh_pkg::coord_type'(x)};
      set_y = {set_y, cvh_pkg::coord_type'(y)};
   endtask

   // sends the queued set, last flag on its final point
   task automatic send_set();
      for (int i = 0; i < set_x.size(); i++)
         send_point(set_x[i], set_y[i], i == set_x.size() - 1);
      set_x.delete();
      set_y.delete();
   endtask

   // random set; narrow ranges give duplicates and collinear points,
   // the full range exercises every coordinate bit
   task automatic random_set(int count);
      int spread;
      int cx;
      int cy;
      spread = $urandom_range(3);
      for (int i = 0; i < count; i++) begin
         case (spread)
            0: begin
               cx = int'(cvh_pkg::coord_type'($urandom()));
               cy = int'(cvh_pkg::coord_type'($urandom()));
            end
            1: begin
               cx = int'($urandom_range(6)) - 3;
               cy = int'($urandom_range(6)) - 3;
            end
            2: begin
               cx = int'($urandom_range(2000)) - 1000;
               cy = int'($urandom_range(2000)) - 1000;
            end
            default: begin
               // corners and axes of the coordinate range
               case ($urandom_range(4))
                  0: cx = -32768;
                  1: cx = -1;
                  2: cx = 0;
                  3: cx = 1;
                  default: cx = 32767;
               endcase
               case ($urandom_range(4))
                  0: cy = -32768;
                  1: cy = -1;
                  2: cy = 0;
                  3: cy = 1;
                  default: cy = 32767;
               endcase
            end
         endcase
         add_point(cx, cy);
      end
      send_set();
   endtask

   initial begin : stimulus
      int count;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // a lone point and a pair: both too few for a hull
      add_point(32767, -32768);
      send_set();
      add_point(-32768, 32767);
      add_point(0, 0);
      send_set();

      // the four corners of the coordinate range
      add_point(-32768, -32768);
      add_point(32767, -32768);
      add_point(32767, 32767);
      add_point(-32768, 32767);
      send_set();

      // leftmost tie on x, collinear edge points and an interior point
      add_point(0, 5);
      add_point(10, 0);
      add_point(0, -5);
      add_point(5, 0);
      add_point(0, 0);
      add_point(5, -5);
      send_set();

      // leftmost point stored twice: wrap can miss its index and hit the guard
      add_point(0, 0);
      add_point(4, 0);
      add_point(0, 4);
      add_point(0, 0);
      send_set();

      // three identical points
      add_point(7, 7);
      add_point(7, 7);
      add_point(7, 7);
      send_set();

      // overfilled store first, then mostly small sets with a few large ones
      random_set(STORE_DEPTH + 4);
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(7) == 0)
            count = $urandom_range(STORE_DEPTH + 8, 20);
         else
            count = $urandom_range(8, 1);
         random_set(count);
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;

      while (hull_sb.hull_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d point sets with %0d points, %0d hull vertices checked",
               hull_sb.runs, hull_sb.points, hull_sb.vertices);
      $display("  %0d sets too small for a hull, %0d stopped by the step guard",
               hull_sb.short_sets, hull_sb.guard_stops);
      if (hull_sb.failures == 0 && hull_sb.hull_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
